>>> hdl/ght_pkg.sv
// ght_pkg: shared constants, codes and control structs for the handle table
// used by ght_ctrl, ght_datapath and generational_handle_table; no dependencies
package ght_pkg;

  // table geometry
  localparam int Slots       = 256;
  localparam int VersionBits = 16;
  localparam int RefBits     = 16;
  localparam int IdxW        = $clog2(Slots);

  // free-slot search: the used map is split into groups, one register per group
  localparam int GroupW    = (Slots < 16) ? Slots : 16;
  localparam int NumGroups = Slots / GroupW;
  localparam int GrpIdxW   = (GroupW > 1) ? $clog2(GroupW) : 1;

  // beat field widths
  localparam int KindW     = 3;
  localparam int HIdxW     = 8;
  localparam int HVerW     = 16;
  localparam int RefFieldW = 16;
  localparam int StatusW   = 3;
  localparam int InDataW   = HIdxW + HVerW + 2 * RefFieldW;
  localparam int OutDataW  = HIdxW + HVerW + 2 * RefFieldW;

  typedef logic signed [VersionBits-1:0] ver_t;
  typedef logic [RefBits-1:0]            ref_t;
  typedef logic [IdxW-1:0]               slot_t;

  typedef enum logic [KindW-1:0] {
    KIND_ALLOC  = 3'd0,
    KIND_ADD    = 3'd1,
    KIND_LOOKUP = 3'd2,
    KIND_FREE   = 3'd3,
    KIND_UPDATE = 3'd4
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 3'd0,
    ST_STALE    = 3'd1,
    ST_FULL     = 3'd2,
    ST_FREED    = 3'd3,
    ST_INUSE    = 3'd4,
    ST_MISMATCH = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_ADDR = 2'd1,
    S_EXEC = 2'd2
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch the input beat
    logic rd_en;     // read the slot stores
    logic rd_alloc;  // read address comes from the free-slot search
    logic exec;      // resolve the operation, write back, load the result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_alloc;  // offered beat is an allocate
  } dp_sts_t;

endpackage

>>> hdl/generational_handle_table.sv
// generational_handle_table: top level of the versioned handle table
// depends on ght_pkg, ght_ctrl and ght_datapath
//
// usage
// - input channel s_axis: one beat per operation; tuser carries the kind
//   (allocate, add with handle, lookup, free, update reference), tdata the
//   handle index and version and the list and entity indexes to store
// - output channel m_axis: exactly one result beat per input beat, in order;
//   tuser carries the status code, tdata the allocated handle and the
//   reference returned by a lookup (fields that do not apply are zero)
// - sequencing: add, lookup, free and update pass from accept through beat
//   capture with slot read, then execute and write back; allocate adds a
//   search step between them, resolving the lowest free slot from the
//   registered per-group search over the used map
// - the single read/write pass over the slot stores per operation sets the
//   rate: one operation at a time, a new beat only once the last has executed
// - reset clears the used map and the version-valid bits at once, so every
//   slot reads as free with version zero; no clearing pass is needed
// - a stalled receiver holds the result register; the next beat is still
//   accepted and waits in execute until the register frees up
module generational_handle_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // handle_index[7:0], handle_version[23:8], list_index[39:24],
  // entity_index[55:40]
  input  logic [ght_pkg::InDataW-1:0]   s_axis_tdata,
  // kind[2:0]
  input  logic [ght_pkg::KindW-1:0]     s_axis_tuser,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // out_index[7:0], out_version[23:8], out_list_index[39:24],
  // out_entity_index[55:40]
  output logic [ght_pkg::OutDataW-1:0]  m_axis_tdata,
  // status[2:0]
  output logic [ght_pkg::StatusW-1:0]   m_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready
);
  import ght_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencing and handshake control
  ght_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // slot stores, free-slot search, operation logic and result register
  ght_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_kind_i    (s_axis_tuser),
    .in_data_i    (s_axis_tdata),
    .out_status_o (m_axis_tuser),
    .out_data_o   (m_axis_tdata)
  );

endmodule

>>> hdl/ght_ctrl.sv
// ght_ctrl: sequencing state machine and result-valid flag of the handle table
// depends on ght_pkg
module ght_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  input  ght_pkg::dp_sts_t sts_i,
  output ght_pkg::dp_cmd_t cmd_o
);
  import ght_pkg::*;

  state_e state_q, state_d;
  logic   m_valid_q, m_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    m_valid_d  = m_valid_q & ~m_tready_i;
    unique case (state_q)
      S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.capture = 1'b1;
          cmd_o.rd_en   = 1'b1;
          state_d       = sts_i.in_alloc ? S_ADDR : S_EXEC;
        end
      end
      S_ADDR: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_alloc = 1'b1;
        state_d        = S_EXEC;
      end
      S_EXEC: begin
        // hold here until the result register can take the new beat
        if (!m_valid_q || m_tready_i) begin
          cmd_o.exec = 1'b1;
          m_valid_d  = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign m_tvalid_o = m_valid_q;

  a_accept_moves_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> (state_q == S_ADDR || state_q == S_EXEC))
    else $error("accepted beat did not start an operation");

  a_addr_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADDR) |=> (state_q == S_EXEC))
    else $error("search stage not followed by execute");

  a_exec_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> m_valid_q)
    else $error("executed operation produced no result beat");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_tready_i) |-> !cmd_o.exec)
    else $error("pending result overwritten");

endmodule

>>> hdl/ght_datapath.sv
// ght_datapath: slot stores, free-slot search, operation logic and result register
// depends on ght_pkg; driven by ght_ctrl commands
module ght_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ght_pkg::dp_cmd_t               cmd_i,
  output ght_pkg::dp_sts_t               sts_o,
  input  logic [ght_pkg::KindW-1:0]      in_kind_i,
  input  logic [ght_pkg::InDataW-1:0]    in_data_i,
  output logic [ght_pkg::StatusW-1:0]    out_status_o,
  output logic [ght_pkg::OutDataW-1:0]   out_data_o
);
  import ght_pkg::*;

  // state stores
  logic [Slots-1:0] used_q;
  logic [Slots-1:0] ver_valid_q;
  ver_t             ver_mem [Slots];
  logic [2*RefBits-1:0] ref_mem [Slots];

  // captured beat
  logic [KindW-1:0]     kind_q;
  logic [HIdxW-1:0]     hidx_q;
  ver_t                 hver_q;
  logic [RefFieldW-1:0] li_q, ei_q;
  logic                 in_range_q;

  // read stage
  ver_t                 rd_ver_raw_q;
  logic                 rd_vvalid_q;
  logic                 rd_used_q;
  logic [2*RefBits-1:0] rd_ref_q;
  slot_t                slot_q;
  logic                 full_q;

  // free-slot search, first level registered every cycle
  logic [NumGroups-1:0] grp_free_q, grp_free_d;
  logic [GrpIdxW-1:0]   grp_low_q [NumGroups];
  logic [GrpIdxW-1:0]   grp_low_d [NumGroups];
  slot_t                alloc_slot;
  logic                 alloc_full;

  logic [HIdxW-1:0]     in_hidx;
  logic [HVerW-1:0]     in_hver;
  slot_t                rd_addr;

  assign in_hidx = in_data_i[HIdxW-1:0];
  assign in_hver = in_data_i[HIdxW +: HVerW];
  assign sts_o.in_alloc = (in_kind_i == KIND_ALLOC);

  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      grp_free_d[g] = 1'b0;
      grp_low_d[g]  = '0;
      for (int b = GroupW - 1; b >= 0; b--) begin
        if (!used_q[g*GroupW + b]) begin
          grp_free_d[g] = 1'b1;
          grp_low_d[g]  = GrpIdxW'(b);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_free_q <= grp_free_d;
    for (int g = 0; g < NumGroups; g++) begin
      grp_low_q[g] <= grp_low_d[g];
    end
  end

  // second level: lowest group that has a free slot
  always_comb begin
    alloc_slot = '0;
    for (int g = NumGroups - 1; g >= 0; g--) begin
      if (grp_free_q[g]) begin
        alloc_slot = IdxW'(g * GroupW + int'(grp_low_q[g]));
      end
    end
    alloc_full = ~|grp_free_q;
  end

  assign rd_addr = cmd_i.rd_alloc ? alloc_slot : IdxW'(in_hidx);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q     <= in_kind_i;
      hidx_q     <= in_hidx;
      hver_q     <= ver_t'(signed'(in_hver));
      li_q       <= in_data_i[HIdxW+HVerW +: RefFieldW];
      ei_q       <= in_data_i[HIdxW+HVerW+RefFieldW +: RefFieldW];
      in_range_q <= (int'(in_hidx) < Slots);
    end
    if (cmd_i.rd_en) begin
      rd_ver_raw_q <= ver_mem[rd_addr];
      rd_ref_q     <= ref_mem[rd_addr];
      rd_vvalid_q  <= ver_valid_q[rd_addr];
      rd_used_q    <= used_q[rd_addr];
    end
    if (cmd_i.rd_alloc) begin
      slot_q <= alloc_slot;
      full_q <= alloc_full;
    end
  end

  // operation logic
  ver_t                 stored_ver;
  logic signed [VersionBits+1:0] nv_wide;
  ver_t                 nv;
  logic                 ver_match;
  status_e              status;
  slot_t                wr_addr;
  logic                 wr_ver_en, wr_ref_en, set_used, clr_used;
  ver_t                 wr_ver;
  logic [IdxW-1:0]      o_idx;
  ver_t                 o_ver;
  logic [RefFieldW-1:0] o_li, o_ei;

  assign stored_ver = rd_vvalid_q ? rd_ver_raw_q : '0;
  assign nv_wide    = -(VersionBits+2)'(stored_ver) + (VersionBits+2)'(1);
  assign ver_match  = (hver_q == stored_ver);

  always_comb begin
    // new version wraps to one when it is zero or leaves the signed range
    if (nv_wide == '0 ||
        (nv_wide[VersionBits+1:VersionBits-1] != '0 &&
         nv_wide[VersionBits+1:VersionBits-1] != '1)) begin
      nv = ver_t'(1);
    end else begin
      nv = nv_wide[VersionBits-1:0];
    end
  end

  always_comb begin
    status    = ST_OK;
    wr_addr   = IdxW'(hidx_q);
    wr_ver_en = 1'b0;
    wr_ref_en = 1'b0;
    set_used  = 1'b0;
    clr_used  = 1'b0;
    wr_ver    = hver_q;
    o_idx     = '0;
    o_ver     = '0;
    o_li      = '0;
    o_ei      = '0;
    if (kind_q == KIND_ALLOC) begin
      wr_addr = slot_q;
      if (full_q) begin
        status = ST_FULL;
      end else begin
        wr_ver    = nv;
        wr_ver_en = 1'b1;
        wr_ref_en = 1'b1;
        set_used  = 1'b1;
        o_idx     = slot_q;
        o_ver     = nv;
      end
    end else if (!in_range_q) begin
      status = ST_STALE;
    end else begin
      unique case (kind_q)
        KIND_ADD: begin
          if (rd_used_q) begin
            status = ST_INUSE;
          end else begin
            wr_ver_en = 1'b1;
            wr_ref_en = 1'b1;
            set_used  = 1'b1;
          end
        end
        KIND_LOOKUP: begin
          if (hver_q == '0 || !rd_used_q || !ver_match) begin
            status = ST_STALE;
          end else begin
            o_li = RefFieldW'(rd_ref_q[RefBits-1:0]);
            o_ei = RefFieldW'(rd_ref_q[2*RefBits-1:RefBits]);
          end
        end
        KIND_FREE: begin
          if (!rd_used_q || !ver_match) begin
            status = ST_FREED;
          end else begin
            wr_ver    = -stored_ver;
            wr_ver_en = 1'b1;
            clr_used  = 1'b1;
          end
        end
        KIND_UPDATE: begin
          if (!rd_used_q || !ver_match) begin
            status = ST_MISMATCH;
          end else begin
            wr_ref_en = 1'b1;
          end
        end
        default: status = ST_STALE;
      endcase
    end
  end

  // write back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      ver_valid_q <= '0;
    end else if (cmd_i.exec) begin
      if (set_used) used_q[wr_addr] <= 1'b1;
      if (clr_used) used_q[wr_addr] <= 1'b0;
      if (wr_ver_en) ver_valid_q[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_ver_en) begin
      ver_mem[wr_addr] <= wr_ver;
    end
    if (cmd_i.exec && wr_ref_en) begin
      ref_mem[wr_addr] <= {RefBits'(ei_q), RefBits'(li_q)};
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_status_o <= status;
      out_data_o   <= {o_ei, o_li, HVerW'(o_ver), HIdxW'(o_idx)};
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for generational_handle_table, driving random and directed
// table operations over the stream ports; depends on ght_pkg and generational_handle_table
module tb_top;
  import ght_pkg::*;

  localparam int VerMax      = 2 ** (VersionBits - 1) - 1;
  localparam int QuietLimit  = 2000;  // cycles with no beat on either side before giving up
  localparam int DrainCycles = 12;    // settle time after the last result

  // kinds past update are undefined and must answer stale
  localparam logic [KindW-1:0] KindFirstUnused = KIND_UPDATE + 1'b1;
  localparam logic [KindW-1:0] KindMax         = '1;

  // one expected result beat
  typedef struct packed {
    status_e status;
    slot_t   idx;
    ver_t    ver;
    ref_t    list_ref;
    ref_t    ent_idx;
  } table_result_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic [InDataW-1:0]   s_axis_tdata  = '0;
  logic [KindW-1:0]     s_axis_tuser  = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic [StatusW-1:0]   m_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;

  // shadow copy of the table, updated when a beat is accepted
  bit   slot_live [Slots] = '{default: 1'b0};
  ver_t slot_ver  [Slots] = '{default: '0};
  ref_t slot_list [Slots] = '{default: '0};
  ref_t slot_ent  [Slots] = '{default: '0};

  table_result_t pending_results[$];

  int  errors          = 0;
  int  ops_sent        = 0;
  int  results_checked = 0;
  int  wrap_hits       = 0;
  int  status_hits [8] = '{default: 0};
  int  quiet_cycles    = 0;

  // idling and hold-off controls shared by sender, receiver and tests
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;
  bit  hold_req   = 1'b0;
  int  hold_len   = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  generational_handle_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  // table behavior: applies one operation to the shadow table, returns its result
  function automatic table_result_t predict_op(input logic [KindW-1:0] kind, input slot_t idx,
                                               input ver_t ver, input ref_t li, input ref_t ei);
    table_result_t res;
    int            free_slot;
    int            nv;
    res = '0;
    res.status = ST_OK;
    case (kind)
      KIND_ALLOC: begin
        // lowest free slot wins
        free_slot = -1;
        for (int i = Slots - 1; i >= 0; i--) begin
          if (!slot_live[i]) free_slot = i;
        end
        if (free_slot < 0) begin
          res.status = ST_FULL;
        end else begin
          // new version is minus the stored one plus one; zero or overflow wraps to 1
          nv = 1 - int'(slot_ver[free_slot]);
          if (nv == 0 || nv > VerMax) begin
            nv = 1;
            wrap_hits++;
          end
          slot_live[free_slot] = 1'b1;
          slot_ver[free_slot]  = ver_t'(nv);
          slot_list[free_slot] = li;
          slot_ent[free_slot]  = ei;
          res.idx = slot_t'(free_slot);
          res.ver = ver_t'(nv);
        end
      end
      KIND_ADD: begin
        if (slot_live[idx]) begin
          res.status = ST_INUSE;
        end else begin
          slot_live[idx] = 1'b1;
          slot_ver[idx]  = ver;
          slot_list[idx] = li;
          slot_ent[idx]  = ei;
        end
      end
      KIND_LOOKUP: begin
        if (ver == '0 || !slot_live[idx] || ver != slot_ver[idx]) begin
          res.status = ST_STALE;
        end else begin
          res.list_ref = slot_list[idx];
          res.ent_idx  = slot_ent[idx];
        end
      end
      KIND_FREE: begin
        if (!slot_live[idx] || ver != slot_ver[idx]) begin
          res.status = ST_FREED;
        end else begin
          // negation wraps, so the most negative version stays put
          slot_ver[idx]  = -slot_ver[idx];
          slot_live[idx] = 1'b0;
        end
      end
      KIND_UPDATE: begin
        if (!slot_live[idx] || ver != slot_ver[idx]) begin
          res.status = ST_MISMATCH;
        end else begin
          slot_list[idx] = li;
          slot_ent[idx]  = ei;
        end
      end
      default: res.status = ST_STALE;
    endcase
    status_hits[res.status]++;
    return res;
  endfunction

  // finds a random slot that is live (or free); returns 0 when there is none
  function automatic bit pick_slot(input bit want_live, output slot_t idx_o);
    int start;
    start = $urandom_range(0, Slots - 1);
    idx_o = slot_t'(start);
    for (int i = 0; i < Slots; i++) begin
      if (slot_live[(start + i) % Slots] == want_live) begin
        idx_o = slot_t'((start + i) % Slots);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // versions lean toward the signed extremes and plus or minus one
  function automatic ver_t rand_version();
    case ($urandom_range(0, 11))
      0:       return ver_t'(VerMax);
      1:       return ver_t'(-VerMax - 1);
      2:       return ver_t'(1);
      3:       return ver_t'(-1);
      default: return ver_t'($urandom);
    endcase
  endfunction

  function automatic ref_t rand_ref();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return ref_t'($urandom);
    endcase
  endfunction

  // sends one operation beat, with an optional gap before it, and records
  // the expected result once the beat is taken
  task automatic send_beat(input logic [KindW-1:0] kind, input slot_t idx, input ver_t ver,
                           input ref_t li, input ref_t ei);
    table_result_t exp_res;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {ei, li, ver, idx};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    exp_res = predict_op(kind, idx, ver, li, ei);
    pending_results = {pending_results, exp_res};
    ops_sent++;
  endtask

  // sender goes quiet until every expected result has been seen
  task automatic settle_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // hand-picked sequence on an empty table: every kind, every status but full
  // and the version wrap corners
  task automatic test_directed();
    send_beat(KIND_ALLOC,  8'd0,   16'sd0,  16'h0000, 16'h0000); // slot 0 gets version 1
    send_beat(KIND_LOOKUP, 8'd0,   16'sd1,  16'h0000, 16'h0000);
    send_beat(KIND_LOOKUP, 8'd0,   16'sd0,  16'h0000, 16'h0000); // uninitialized handle
    send_beat(KIND_LOOKUP, 8'd0,   16'sd2,  16'h0000, 16'h0000); // wrong version
    send_beat(KIND_UPDATE, 8'd0,   16'sd1,  16'hFFFF, 16'hFFFF);
    send_beat(KIND_LOOKUP, 8'd0,   16'sd1,  16'h0000, 16'h0000);
    send_beat(KIND_UPDATE, 8'd0,   16'sd5,  16'h1234, 16'h5678); // stale update
    send_beat(KIND_ADD,    8'd0,   16'sd1,  16'h1111, 16'h2222); // slot already in use
    send_beat(KIND_FREE,   8'd0,   16'sd2,  16'h0000, 16'h0000); // free with wrong version
    send_beat(KIND_FREE,   8'd0,   16'sd1,  16'h0000, 16'h0000); // version goes to -1
    send_beat(KIND_FREE,   8'd0,  -16'sd1,  16'h0000, 16'h0000); // double free
    send_beat(KIND_LOOKUP, 8'd0,  -16'sd1,  16'h0000, 16'h0000); // lookup of a free slot
    send_beat(KIND_UPDATE, 8'd0,  -16'sd1,  16'hAAAA, 16'h5555); // update of a free slot
    // largest positive version, freed, then reallocated: overflow wraps to 1
    send_beat(KIND_ADD,    8'd0,   16'sd32767, 16'h0F0F, 16'hF0F0);
    send_beat(KIND_FREE,   8'd0,   16'sd32767, 16'h0000, 16'h0000);
    send_beat(KIND_ALLOC,  8'hFF, -16'sd1,  16'h00FF, 16'hFF00);
    send_beat(KIND_FREE,   8'd0,   16'sd1,  16'h0000, 16'h0000);
    // most negative version: freeing keeps it, reallocation wraps to 1
    send_beat(KIND_ADD,    8'd0,  -16'sd32768, 16'hFFFF, 16'h0000);
    send_beat(KIND_FREE,   8'd0,  -16'sd32768, 16'h0000, 16'h0000);
    send_beat(KIND_ALLOC,  8'd0,   16'sd0,  16'h8000, 16'h0001);
    // top slot with all-ones references
    send_beat(KIND_ADD,    8'hFF,  16'sd32767, 16'hFFFF, 16'hFFFF);
    send_beat(KIND_LOOKUP, 8'hFF,  16'sd32767, 16'h0000, 16'h0000);
    // live version -1, freed to 1, reallocated: the new version would be zero
    send_beat(KIND_ADD,    8'd1,  -16'sd1,  16'h0001, 16'h0002);
    send_beat(KIND_FREE,   8'd1,  -16'sd1,  16'h0000, 16'h0000);
    send_beat(KIND_ALLOC,  8'd0,   16'sd0,  16'h0003, 16'h0004);
    // undefined kinds
    for (int k = KindFirstUnused; k <= KindMax; k++) begin
      send_beat(KindW'(k), 8'd0, 16'sd1, 16'hFFFF, 16'hFFFF);
    end
  endtask

  // mostly well-formed traffic on live handles, with stale handles, wrong adds and noise
  task automatic test_random_traffic(input int n_ops, input bit with_gaps);
    int               pick;
    bit               have_live;
    slot_t            live_idx;
    slot_t            free_idx;
    ver_t             v;
    logic [KindW-1:0] k;
    for (int n = 0; n < n_ops; n++) begin
      // sender gaps come in stretches, with gap-free stretches between
      tx_idle_on = with_gaps && ((n / 40) % 3 != 2);
      pick      = $urandom_range(0, 99);
      have_live = pick_slot(1'b1, live_idx);
      if (pick < 18 || !have_live) begin
        send_beat(KIND_ALLOC, slot_t'($urandom), rand_version(), rand_ref(), rand_ref());
      end else if (pick < 33) begin
        send_beat(KIND_LOOKUP, live_idx, slot_ver[live_idx], rand_ref(), rand_ref());
      end else if (pick < 48) begin
        send_beat(KIND_UPDATE, live_idx, slot_ver[live_idx], rand_ref(), rand_ref());
      end else if (pick < 68) begin
        send_beat(KIND_FREE, live_idx, slot_ver[live_idx], rand_ref(), rand_ref());
      end else if (pick < 75) begin
        if (pick_slot(1'b0, free_idx)) begin
          send_beat(KIND_ADD, free_idx, rand_version(), rand_ref(), rand_ref());
        end else begin
          send_beat(KIND_ADD, live_idx, rand_version(), rand_ref(), rand_ref());
        end
      end else if (pick < 85) begin
        // stale handle: zero version, near-miss version, or the handle from before a free
        case ($urandom_range(0, 2))
          0:       k = KIND_LOOKUP;
          1:       k = KIND_FREE;
          default: k = KIND_UPDATE;
        endcase
        case ($urandom_range(0, 3))
          0: v = '0;
          1: v = slot_ver[live_idx] + ver_t'($urandom_range(1, 3));
          default: begin
            if (pick_slot(1'b0, free_idx)) begin
              live_idx = free_idx;
              v = -slot_ver[free_idx];
            end else begin
              v = slot_ver[live_idx] - 1'b1;
            end
          end
        endcase
        send_beat(k, live_idx, v, rand_ref(), rand_ref());
      end else if (pick < 90) begin
        send_beat(KIND_ADD, live_idx, rand_version(), rand_ref(), rand_ref());
      end else begin
        k = KindW'($urandom_range(0, KindMax));
        send_beat(k, slot_t'($urandom), ver_t'($urandom), ref_t'($urandom), ref_t'($urandom));
      end
    end
  endtask

  // receiver holds off for a long stretch while beats keep coming, so the
  // block backs up and stalls its input
  task automatic test_output_stall();
    slot_t idx;
    tx_idle_on = 1'b0;
    hold_len   = $urandom_range(60, 90);
    hold_req   = 1'b1;
    while (hold_req) @(posedge clk_i);
    for (int n = 0; n < 16; n++) begin
      if (n % 2 == 1 && pick_slot(1'b1, idx)) begin
        send_beat(KIND_LOOKUP, idx, slot_ver[idx], rand_ref(), rand_ref());
      end else begin
        send_beat(KIND_ALLOC, '0, '0, rand_ref(), rand_ref());
      end
    end
    settle_results();
    tx_idle_on = 1'b1;
  endtask

  // fill every slot, hit the full table, then free about half of it
  task automatic test_table_full();
    slot_t idx;
    while (pick_slot(1'b0, idx)) begin
      if ($urandom_range(0, 4) == 0) begin
        send_beat(KIND_ADD, idx, rand_version(), rand_ref(), rand_ref());
      end else begin
        send_beat(KIND_ALLOC, slot_t'($urandom), rand_version(), rand_ref(), rand_ref());
      end
    end
    repeat (3) send_beat(KIND_ALLOC, '0, '0, rand_ref(), rand_ref());
    send_beat(KIND_ADD, slot_t'($urandom), rand_version(), rand_ref(), rand_ref());
    for (int n = 0; n < Slots / 2; n++) begin
      if (pick_slot(1'b1, idx)) begin
        send_beat(KIND_FREE, idx, slot_ver[idx], rand_ref(), rand_ref());
      end
    end
  endtask

  // receiver: ready in random bursts, or a long hold-off on request
  initial begin : result_sink
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        for (int n = 0; n < hold_len; n++) @(posedge clk_i);
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  function automatic void check_field(input string what, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, what, want, got);
      errors++;
    end
  endfunction

  // every result beat is compared against the oldest expected result
  always @(posedge clk_i) begin : result_check
    table_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result beat, expected none, actual status %0d data %0h",
                 $time, m_axis_tuser, m_axis_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        check_field("status", 16'(want.status), 16'(m_axis_tuser));
        check_field("out_index", 16'(want.idx), 16'(m_axis_tdata[HIdxW-1:0]));
        check_field("out_version", want.ver, m_axis_tdata[HIdxW +: HVerW]);
        check_field("out_list_index", want.list_ref, m_axis_tdata[HIdxW+HVerW +: RefFieldW]);
        check_field("out_entity_index", want.ent_idx,
                    m_axis_tdata[HIdxW+HVerW+RefFieldW +: RefFieldW]);
      end
    end
  end

  // watchdog: too long with no beat on either side ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("%0t ns: no beat for %0d cycles, %0d results outstanding", $time, quiet_cycles,
               pending_results.size());
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : run
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    settle_results();
    test_random_traffic(620, 1'b1);
    settle_results();
    test_output_stall();
    test_table_full();
    settle_results();
    test_random_traffic(150, 1'b1);
    settle_results();
    // closing stretch at full rate on both sides
    rx_idle_on = 1'b0;
    test_random_traffic(80, 1'b0);
    settle_results();
    repeat (DrainCycles) @(posedge clk_i);

    $display("tb_top: %0d operations sent, %0d results compared, %0d version wraps on allocate",
             ops_sent, results_checked, wrap_hits);
    $display("tb_top: status mix ok %0d, stale %0d, full %0d, freed %0d, in use %0d, mismatch %0d",
             status_hits[ST_OK], status_hits[ST_STALE], status_hits[ST_FULL],
             status_hits[ST_FREED], status_hits[ST_INUSE], status_hits[ST_MISMATCH]);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/ght_pkg.sv
hdl/ght_ctrl.sv
hdl/ght_datapath.sv
hdl/generational_handle_table.sv
tb/tb_top.sv
